>>> hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative LRU write-back cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

    localparam int ADDR_W    = 10;
    localparam int DATA_W    = 32;
    localparam int MAX_OFF_W = 6;
    localparam int MAX_SET_W = 8;

    localparam int NUM_SETS_DEF    = 4;
    localparam int NUM_WAYS_DEF    = 4;
    localparam int BLOCK_WORDS_DEF = 4;
    localparam int MEM_WORDS_DEF   = 1024;

    // Division by a constant is done as a multiply by a scaled reciprocal.
    localparam int RECIP_SH = 26;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = ADDR_W + RECIP_W;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               hit;
    } t_rsp;

    typedef struct packed {
        t_cmd                  cmd;
        logic [ADDR_W-1:0]     blk;
        logic [MAX_OFF_W-1:0]  off;
        logic [MAX_SET_W-1:0]  set;
        logic [DATA_W-1:0]     wdata;
    } t_job;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WB_RD,
        S_WB_WR,
        S_FILL_RD,
        S_FILL_WR,
        S_FILL_END,
        S_ACCESS,
        S_LOAD_RD,
        S_FL_CHK,
        S_FL_NEXT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/sac_fifo.sv
// ----------------------------------------------------------------------------
// sac_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = sac_pkg::FIFO_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// Takes requests, splits the address into block, offset and set over three
// pipeline stages, and queues the decoded jobs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_front #(
    parameter int NUM_SETS    = sac_pkg::NUM_SETS_DEF,
    parameter int BLOCK_WORDS = sac_pkg::BLOCK_WORDS_DEF,
    parameter int MEM_WORDS   = sac_pkg::MEM_WORDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_hold,
    input  wire logic          i_push,
    input  wire sac_pkg::t_req i_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output sac_pkg::t_job      o_job,
    output logic               o_job_valid
);

    localparam int AW = sac_pkg::ADDR_W;
    localparam int PW = sac_pkg::PROD_W;
    localparam int SH = sac_pkg::RECIP_SH;
    localparam int RW = sac_pkg::RECIP_W;
    localparam logic [RW-1:0] RM =
        RW'(((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
    localparam logic [RW-1:0] RB =
        RW'(((64'd1 << SH) + 64'(BLOCK_WORDS) - 64'd1) / 64'(BLOCK_WORDS));
    localparam logic [RW-1:0] RQ =
        RW'(((64'd1 << SH) + 64'(BLOCK_WORDS * NUM_SETS) - 64'd1)
            / 64'(BLOCK_WORDS * NUM_SETS));

    logic                        r1_v, r2_v, r3_v;
    sac_pkg::t_cmd               r1_cmd, r2_cmd, r3_cmd;
    logic [AW-1:0]               r1_addr, r1_qm, r2_a, r3_a, r3_blk, r3_qs;
    logic [sac_pkg::DATA_W-1:0]  r1_wd, r2_wd, r3_wd;
    logic                        ld1, ld2, ld3, mv3, q_full;
    logic [PW-1:0]               p_m, p_b, p_q;
    sac_pkg::t_job               job;
    logic                        job_empty;

    assign mv3    = r3_v && !q_full;
    assign ld3    = r2_v && (!r3_v || mv3);
    assign ld2    = r1_v && (!r2_v || ld3);
    assign o_full = i_hold || (r1_v && !ld2);
    assign ld1    = i_push && !o_full;

    assign p_m = PW'(i_req.address) * PW'(RM);
    assign p_b = PW'(r2_a) * PW'(RB);
    assign p_q = PW'(r2_a) * PW'(RQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= ld1 || (r1_v && !ld2);
            r2_v <= ld2 || (r2_v && !ld3);
            r3_v <= ld3 || (r3_v && !mv3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_cmd  <= i_req.cmd;
            r1_addr <= i_req.address;
            r1_wd   <= i_req.write_data;
            r1_qm   <= AW'(p_m >> SH);
        end
        if (ld2) begin
            r2_cmd <= r1_cmd;
            r2_wd  <= r1_wd;
            r2_a   <= AW'(32'(r1_addr) - 32'(r1_qm) * 32'(MEM_WORDS));
        end
        if (ld3) begin
            r3_cmd <= r2_cmd;
            r3_wd  <= r2_wd;
            r3_a   <= r2_a;
            r3_blk <= AW'(p_b >> SH);
            r3_qs  <= AW'(p_q >> SH);
        end
    end

    always_comb begin
        job.cmd   = r3_cmd;
        job.blk   = r3_blk;
        job.off   = sac_pkg::MAX_OFF_W'(32'(r3_a) - 32'(r3_blk) * 32'(BLOCK_WORDS));
        job.set   = sac_pkg::MAX_SET_W'(32'(r3_blk) - 32'(r3_qs) * 32'(NUM_SETS));
        job.wdata = r3_wd;
    end

    sac_fifo #(
        .W     ($bits(sac_pkg::t_job)),
        .DEPTH (sac_pkg::FIFO_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r3_v),
        .i_data  (job),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_data  (o_job),
        .o_empty (job_empty)
    );

    assign o_job_valid = !job_empty;

endmodule

`default_nettype wire

>>> hw/rtl/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back
// Cache engine: tag lookup, victim write-back, line fill, access, LRU update
// and the flush walk. Also clears the backing memory after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_back #(
    parameter int NUM_SETS    = sac_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = sac_pkg::NUM_WAYS_DEF,
    parameter int BLOCK_WORDS = sac_pkg::BLOCK_WORDS_DEF,
    parameter int MEM_WORDS   = sac_pkg::MEM_WORDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sac_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_pop,
    output logic               o_clearing,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output sac_pkg::t_rsp      o_res
);

    localparam int AW    = sac_pkg::ADDR_W;
    localparam int DW    = sac_pkg::DATA_W;
    localparam int LINES = NUM_SETS * NUM_WAYS;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int OFF_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int LN_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LD_W  = (LINES * BLOCK_WORDS > 1) ? $clog2(LINES * BLOCK_WORDS) : 1;
    localparam int MA_W  = $clog2(MEM_WORDS);
    localparam int ROW_W = NUM_WAYS * AW;

    // Storage
    logic [ROW_W-1:0] tag_mem  [NUM_SETS];
    logic [DW-1:0]    data_mem [LINES * BLOCK_WORDS];
    logic [DW-1:0]    back_mem [MEM_WORDS];
    logic [ROW_W-1:0] r_tag_row;
    logic [DW-1:0]    r_dat, r_bdat;

    logic             r_valid [LINES];
    logic             r_dirty [LINES];
    logic [WAY_W-1:0] r_age   [LINES];

    sac_pkg::t_state  r_state, n_state;
    sac_pkg::t_cmd    r_cmd;
    logic [AW-1:0]    r_blk;
    logic [OFF_W-1:0] r_off;
    logic [DW-1:0]    r_wd;
    logic [SET_W-1:0] r_set, n_set;
    logic [WAY_W-1:0] r_way, n_way;
    logic             r_hit, n_hit;
    logic [OFF_W-1:0] r_k, n_k;
    logic [MA_W-1:0]  r_base, n_base;
    logic             r_flush, n_flush;
    logic [MA_W-1:0]  r_clr_idx;

    // Memory port controls
    logic             tag_re, tag_we;
    logic [SET_W-1:0] tag_raddr;
    logic [ROW_W-1:0] tag_wrow;
    logic             dat_re, dat_we;
    logic [LD_W-1:0]  dat_raddr, dat_waddr;
    logic [DW-1:0]    dat_wdata;
    logic             bk_re, bk_we;
    logic [MA_W-1:0]  bk_raddr, bk_waddr;
    logic [DW-1:0]    bk_wdata;

    // Line bookkeeping strobes
    logic             take_job, set_valid, clr_dirty, set_dirty, touch;

    logic [LN_W-1:0]  line_idx;
    logic [LD_W-1:0]  word_addr, acc_addr;
    logic [MA_W:0]    mem_sum;
    logic [MA_W-1:0]  mem_idx;
    logic [AW-1:0]    way_tag;
    logic [NUM_WAYS-1:0] hitv, invv, oldv;
    logic [WAY_W-1:0] hit_way, inv_way, old_way, vic_way;
    logic [LN_W-1:0]  vic_line;

    assign line_idx  = LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(r_way));
    assign word_addr = LD_W'(32'(line_idx) * 32'(BLOCK_WORDS) + 32'(r_k));
    assign acc_addr  = LD_W'(32'(line_idx) * 32'(BLOCK_WORDS) + 32'(r_off));
    assign mem_sum   = (MA_W + 1)'(r_base) + (MA_W + 1)'(r_k);
    // A block that runs past the end of memory wraps to its start.
    assign mem_idx   = (mem_sum >= (MA_W + 1)'(MEM_WORDS))
                     ? MA_W'(mem_sum - (MA_W + 1)'(MEM_WORDS)) : MA_W'(mem_sum);
    assign way_tag   = r_tag_row[32'(r_way) * AW +: AW];
    assign o_clearing = (r_state == sac_pkg::S_CLEAR);

    // Way classification for the set held in r_tag_row.
    always_comb begin
        logic [LN_W-1:0] ln;
        hit_way = '0;
        inv_way = '0;
        old_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            ln      = LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(w));
            hitv[w] = r_valid[ln] && (r_tag_row[w * AW +: AW] == r_blk);
            invv[w] = !r_valid[ln];
            // Ages in a set are always a permutation, so the oldest is unique.
            oldv[w] = (r_age[ln] == WAY_W'(NUM_WAYS - 1));
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) hit_way = WAY_W'(w);
            if (invv[w]) inv_way = WAY_W'(w);
            if (oldv[w]) old_way = WAY_W'(w);
        end
        vic_way  = (|invv) ? inv_way : old_way;
        vic_line = LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(vic_way));
    end

    always_comb begin
        n_state   = r_state;
        n_set     = r_set;
        n_way     = r_way;
        n_hit     = r_hit;
        n_k       = r_k;
        n_base    = r_base;
        n_flush   = r_flush;
        take_job  = 1'b0;
        set_valid = 1'b0;
        clr_dirty = 1'b0;
        set_dirty = 1'b0;
        touch     = 1'b0;
        tag_re    = 1'b0;
        tag_raddr = r_set;
        tag_we    = 1'b0;
        tag_wrow  = r_tag_row;
        dat_re    = 1'b0;
        dat_raddr = word_addr;
        dat_we    = 1'b0;
        dat_waddr = word_addr;
        dat_wdata = r_bdat;
        bk_re     = 1'b0;
        bk_raddr  = mem_idx;
        bk_we     = 1'b0;
        bk_waddr  = mem_idx;
        bk_wdata  = r_dat;
        o_res_push = 1'b0;
        o_res      = '0;

        unique case (r_state)
            sac_pkg::S_CLEAR: begin
                bk_we    = 1'b1;
                bk_waddr = r_clr_idx;
                bk_wdata = '0;
                if (r_clr_idx == MA_W'(MEM_WORDS - 1)) begin
                    n_state = sac_pkg::S_IDLE;
                end
            end
            sac_pkg::S_IDLE: begin
                if (i_job_valid && !i_res_full) begin
                    take_job = 1'b1;
                    n_set    = SET_W'(i_job.set);
                    n_way    = '0;
                    unique case (i_job.cmd)
                        sac_pkg::CMD_LOAD, sac_pkg::CMD_STORE: begin
                            tag_re    = 1'b1;
                            tag_raddr = SET_W'(i_job.set);
                            n_state   = sac_pkg::S_LOOK;
                        end
                        sac_pkg::CMD_FLUSH: begin
                            n_set     = '0;
                            tag_re    = 1'b1;
                            tag_raddr = '0;
                            n_flush   = 1'b1;
                            n_state   = sac_pkg::S_FL_CHK;
                        end
                        sac_pkg::CMD_NOP: begin
                            o_res_push = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            sac_pkg::S_LOOK: begin
                n_k = '0;
                if (|hitv) begin
                    n_way   = hit_way;
                    n_hit   = 1'b1;
                    n_state = sac_pkg::S_ACCESS;
                end else begin
                    n_way = vic_way;
                    n_hit = 1'b0;
                    if (r_valid[vic_line] && r_dirty[vic_line]) begin
                        n_base  = MA_W'(32'(r_tag_row[32'(vic_way) * AW +: AW])
                                        * 32'(BLOCK_WORDS));
                        n_state = sac_pkg::S_WB_RD;
                    end else begin
                        n_base  = MA_W'(32'(r_blk) * 32'(BLOCK_WORDS));
                        n_state = sac_pkg::S_FILL_RD;
                    end
                end
            end
            sac_pkg::S_WB_RD: begin
                dat_re  = 1'b1;
                n_state = sac_pkg::S_WB_WR;
            end
            sac_pkg::S_WB_WR: begin
                bk_we = 1'b1;
                if (r_k == OFF_W'(BLOCK_WORDS - 1)) begin
                    clr_dirty = 1'b1;
                    n_k       = '0;
                    if (r_flush) begin
                        n_state = sac_pkg::S_FL_NEXT;
                    end else begin
                        n_base  = MA_W'(32'(r_blk) * 32'(BLOCK_WORDS));
                        n_state = sac_pkg::S_FILL_RD;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = sac_pkg::S_WB_RD;
                end
            end
            sac_pkg::S_FILL_RD: begin
                bk_re   = 1'b1;
                n_state = sac_pkg::S_FILL_WR;
            end
            sac_pkg::S_FILL_WR: begin
                dat_we = 1'b1;
                if (r_k == OFF_W'(BLOCK_WORDS - 1)) begin
                    n_k     = '0;
                    n_state = sac_pkg::S_FILL_END;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = sac_pkg::S_FILL_RD;
                end
            end
            sac_pkg::S_FILL_END: begin
                tag_we = 1'b1;
                tag_wrow[32'(r_way) * AW +: AW] = r_blk;
                set_valid = 1'b1;
                n_state   = sac_pkg::S_ACCESS;
            end
            sac_pkg::S_ACCESS: begin
                touch = 1'b1;
                if (r_cmd == sac_pkg::CMD_STORE) begin
                    dat_we         = 1'b1;
                    dat_waddr      = acc_addr;
                    dat_wdata      = r_wd;
                    set_dirty      = 1'b1;
                    o_res_push     = 1'b1;
                    o_res.read_data = r_wd;
                    o_res.hit      = r_hit;
                    n_state        = sac_pkg::S_IDLE;
                end else begin
                    dat_re    = 1'b1;
                    dat_raddr = acc_addr;
                    n_state   = sac_pkg::S_LOAD_RD;
                end
            end
            sac_pkg::S_LOAD_RD: begin
                o_res_push      = 1'b1;
                o_res.read_data = r_dat;
                o_res.hit       = r_hit;
                n_state         = sac_pkg::S_IDLE;
            end
            sac_pkg::S_FL_CHK: begin
                n_k = '0;
                if (r_valid[line_idx] && r_dirty[line_idx]) begin
                    n_base  = MA_W'(32'(way_tag) * 32'(BLOCK_WORDS));
                    n_state = sac_pkg::S_WB_RD;
                end else begin
                    n_state = sac_pkg::S_FL_NEXT;
                end
            end
            sac_pkg::S_FL_NEXT: begin
                if (r_way == WAY_W'(NUM_WAYS - 1)) begin
                    if (r_set == SET_W'(NUM_SETS - 1)) begin
                        n_flush    = 1'b0;
                        o_res_push = 1'b1;
                        n_state    = sac_pkg::S_IDLE;
                    end else begin
                        n_way     = '0;
                        n_set     = r_set + 1'b1;
                        tag_re    = 1'b1;
                        tag_raddr = r_set + 1'b1;
                        n_state   = sac_pkg::S_FL_CHK;
                    end
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = sac_pkg::S_FL_CHK;
                end
            end
            default: n_state = sac_pkg::S_IDLE;
        endcase
    end

    assign o_job_pop = take_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sac_pkg::S_CLEAR;
            r_clr_idx <= '0;
            r_flush   <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_age[i]   <= WAY_W'(i % NUM_WAYS);
            end
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            if (r_state == sac_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (set_valid) begin
                r_valid[line_idx] <= 1'b1;
                r_dirty[line_idx] <= 1'b0;
            end
            if (clr_dirty) begin
                r_dirty[line_idx] <= 1'b0;
            end
            if (set_dirty) begin
                r_dirty[line_idx] <= 1'b1;
            end
            if (touch) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (r_age[LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(w))]
                        < r_age[line_idx]) begin
                        r_age[LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(w))] <=
                            r_age[LN_W'(32'(r_set) * 32'(NUM_WAYS) + 32'(w))] + 1'b1;
                    end
                end
                r_age[line_idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_set  <= n_set;
        r_way  <= n_way;
        r_hit  <= n_hit;
        r_k    <= n_k;
        r_base <= n_base;
        if (take_job) begin
            r_cmd <= i_job.cmd;
            r_blk <= i_job.blk;
            r_off <= OFF_W'(i_job.off);
            r_wd  <= i_job.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[r_set] <= tag_wrow;
        end
        if (tag_re) begin
            r_tag_row <= tag_mem[tag_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            data_mem[dat_waddr] <= dat_wdata;
        end
        if (dat_re) begin
            r_dat <= data_mem[dat_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            back_mem[bk_waddr] <= bk_wdata;
        end
        if (bk_re) begin
            r_bdat <= back_mem[bk_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/set_assoc_lru_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache
// Set-associative write-allocate write-back cache with LRU replacement in
// front of a word-addressed backing memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Beat
//  request   in         push / full      i_req  (cmd, address, write_data)
//  result    out        empty / pop      o_rsp  (read_data, hit)
//
//  Requests pass a three-stage decode pipeline and a two-entry job queue.
//  The engine handles a hit as a tag lookup and an access, a load adding a
//  data read; a miss adds a word-by-word fill and a tag install, and first a
//  word-by-word write-back when the victim is dirty. Flush walks every line
//  and writes back each dirty line word by word. Each word is moved as a read
//  then a write through the line-data and backing memories.
//  After reset the backing memory is cleared, with full held high meanwhile.
//  A result waits in a two-entry queue; the engine starts a job only when
//  that queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache #(
    parameter int NUM_SETS    = sac_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = sac_pkg::NUM_WAYS_DEF,
    parameter int BLOCK_WORDS = sac_pkg::BLOCK_WORDS_DEF,
    parameter int MEM_WORDS   = sac_pkg::MEM_WORDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire sac_pkg::t_req i_req,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output sac_pkg::t_rsp      o_rsp
);

    sac_pkg::t_job job;
    logic          job_valid, job_pop, clearing;
    logic          res_full, res_push;
    sac_pkg::t_rsp res;

    sac_front #(
        .NUM_SETS    (NUM_SETS),
        .BLOCK_WORDS (BLOCK_WORDS),
        .MEM_WORDS   (MEM_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .i_pop       (job_pop),
        .o_job       (job),
        .o_job_valid (job_valid)
    );

    sac_back #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .BLOCK_WORDS (BLOCK_WORDS),
        .MEM_WORDS   (MEM_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    sac_fifo #(
        .W     ($bits(sac_pkg::t_rsp)),
        .DEPTH (sac_pkg::FIFO_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
